// ----- rtl/core/lnas_pkg.sv -----
// ----------------------------------------------------------------------------
// lnas_pkg
// Shared constants and types of the four-neighbor light averaging stencil.
// ----------------------------------------------------------------------------
`default_nettype none

package lnas_pkg;

    // Row store geometry
    localparam int MAX_WIDTH = 1024;
    localparam int ADDR_W    = $clog2(MAX_WIDTH);
    localparam int WCNT_W    = $clog2(MAX_WIDTH + 1);

    // Field widths
    localparam int CH_W      = 16;
    localparam int FW_W      = 11;
    localparam int FH_W      = 16;
    localparam int GAIN_W    = 16;
    localparam int SUM_W     = CH_W + 2;
    localparam int NUM_OPS   = 4;
    localparam int CNT_W     = 3;
    localparam int PROD_W    = SUM_W + GAIN_W;

    // Scaling constants
    localparam int GAIN_SHIFT = 14;
    localparam int SHIFTED_W  = PROD_W - GAIN_SHIFT;
    localparam logic [SHIFTED_W-1:0] SAT_LIMIT = SHIFTED_W'(48960);
    // floor(g / 3) = (g * DIV3_MULT) >> DIV3_SHIFT for every 16-bit g
    localparam int DIV3_SHIFT = 17;
    localparam logic [DIV3_SHIFT-1:0] DIV3_MULT = DIV3_SHIFT'(43691);

    // APB register map
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;
    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] REG_FALLOFF_GAIN = 2'd2;

    // Reset values
    localparam logic [FW_W-1:0]   RST_FRAME_WIDTH  = FW_W'(640);
    localparam logic [FH_W-1:0]   RST_FRAME_HEIGHT = FH_W'(480);
    localparam logic [GAIN_W-1:0] RST_FALLOFF_GAIN = GAIN_W'(15565);

    // Neighbor operand slots, consumed one per cell in this order
    localparam int OP_RIGHT = 0;
    localparam int OP_LEFT  = 1;
    localparam int OP_DOWN  = 2;
    localparam int OP_UP    = 3;

    typedef logic [CH_W-1:0] t_chan;

    typedef struct packed {
        t_chan red;
        t_chan green;
        t_chan blue;
    } t_rgb;

    typedef struct packed {
        logic [SUM_W-1:0] red;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] blue;
    } t_rgb_sum;

    typedef struct packed {
        logic present;
        t_rgb rgb;
    } t_operand;

    // Word handed from one accumulate cell to the next
    typedef struct packed {
        logic                     valid;
        logic                     last;
        logic [CNT_W-1:0]         count;
        t_rgb_sum                 sum;
        t_operand [NUM_OPS-1:0]   ops;
    } t_cell_bus;

endpackage

`default_nettype wire

// ----- rtl/core/lnas_cell.sv -----
// ----------------------------------------------------------------------------
// lnas_cell
// Accumulate cell: adds the head neighbor operand to the running sums when
// that neighbor is in frame, counts it, and hands the word to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module lnas_cell (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  lnas_pkg::t_cell_bus  i_bus,
    output logic                 o_ready,
    input  wire                  i_ready,
    output lnas_pkg::t_cell_bus  o_bus
);

    logic                r_valid;
    lnas_pkg::t_cell_bus r_bus;
    lnas_pkg::t_cell_bus n_bus;
    logic                w_load;

    assign o_ready = !r_valid || i_ready;
    assign w_load  = o_ready;

    // Add head operand, shift the rest down one slot
    always_comb begin
        n_bus = i_bus;
        if (i_bus.ops[0].present) begin
            n_bus.sum.red   = i_bus.sum.red   + lnas_pkg::SUM_W'(i_bus.ops[0].rgb.red);
            n_bus.sum.green = i_bus.sum.green + lnas_pkg::SUM_W'(i_bus.ops[0].rgb.green);
            n_bus.sum.blue  = i_bus.sum.blue  + lnas_pkg::SUM_W'(i_bus.ops[0].rgb.blue);
            n_bus.count     = i_bus.count + lnas_pkg::CNT_W'(1);
        end
        for (int k = 0; k < lnas_pkg::NUM_OPS - 1; k++) begin
            n_bus.ops[k] = i_bus.ops[k+1];
        end
        n_bus.ops[lnas_pkg::NUM_OPS-1] = '0;
    end

    // Valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= i_bus.valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_bus <= n_bus;
        end
    end

    always_comb begin
        o_bus       = r_bus;
        o_bus.valid = r_valid;
    end

endmodule

`default_nettype wire

// ----- rtl/core/lnas_scale.sv -----
// ----------------------------------------------------------------------------
// lnas_scale
// Scales the neighbor sums by gain / count and saturates at 765.0.
// Three stages: factor select, multiply, shift and clamp (output register).
// ----------------------------------------------------------------------------
`default_nettype none

module lnas_scale (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire [lnas_pkg::GAIN_W-1:0]            i_gain,
    input  lnas_pkg::t_cell_bus                   i_bus,
    output logic                                  o_ready,
    output logic                                  o_valid,
    input  wire                                   i_ready,
    output lnas_pkg::t_rgb                        o_rgb,
    output logic                                  o_last
);

    localparam int DIV3_PROD_W = lnas_pkg::GAIN_W + lnas_pkg::DIV3_SHIFT;

    // gain / 3, kept ready from the register value
    logic [DIV3_PROD_W-1:0]      w_div3_prod;
    logic [lnas_pkg::GAIN_W-1:0] r_gain_div3;

    assign w_div3_prod = DIV3_PROD_W'(i_gain) * DIV3_PROD_W'(lnas_pkg::DIV3_MULT);

    always_ff @(posedge i_clk) begin
        r_gain_div3 <= w_div3_prod[DIV3_PROD_W-1 -: lnas_pkg::GAIN_W];
    end

    // Stage ready chain
    logic r1_valid, r2_valid, r3_valid;
    logic w_rdy1, w_rdy2, w_rdy3;

    assign w_rdy3  = !r3_valid || i_ready;
    assign w_rdy2  = !r2_valid || w_rdy3;
    assign w_rdy1  = !r1_valid || w_rdy2;
    assign o_ready = w_rdy1;

    // Stage 1: factor select
    logic [lnas_pkg::GAIN_W-1:0] n_factor;
    logic [lnas_pkg::GAIN_W-1:0] r1_factor;
    lnas_pkg::t_rgb_sum          r1_sum;
    logic                        r1_last;

    always_comb begin
        case (i_bus.count)
            lnas_pkg::CNT_W'(1): n_factor = i_gain;
            lnas_pkg::CNT_W'(2): n_factor = i_gain >> 1;
            lnas_pkg::CNT_W'(3): n_factor = r_gain_div3;
            lnas_pkg::CNT_W'(4): n_factor = i_gain >> 2;
            default:             n_factor = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (w_rdy1) begin
            r1_valid <= i_bus.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r1_factor <= n_factor;
            r1_sum    <= i_bus.sum;
            r1_last   <= i_bus.last;
        end
    end

    // Stage 2: one multiplier per channel
    logic [lnas_pkg::PROD_W-1:0] r2_red, r2_green, r2_blue;
    logic                        r2_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (w_rdy2) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy2) begin
            r2_red   <= lnas_pkg::PROD_W'(r1_sum.red)   * lnas_pkg::PROD_W'(r1_factor);
            r2_green <= lnas_pkg::PROD_W'(r1_sum.green) * lnas_pkg::PROD_W'(r1_factor);
            r2_blue  <= lnas_pkg::PROD_W'(r1_sum.blue)  * lnas_pkg::PROD_W'(r1_factor);
            r2_last  <= r1_last;
        end
    end

    // Stage 3: drop fraction bits and saturate
    logic [lnas_pkg::SHIFTED_W-1:0] w_sh_red, w_sh_green, w_sh_blue;
    lnas_pkg::t_rgb                 n_rgb;
    lnas_pkg::t_rgb                 r3_rgb;
    logic                           r3_last;

    assign w_sh_red   = r2_red[lnas_pkg::PROD_W-1:lnas_pkg::GAIN_SHIFT];
    assign w_sh_green = r2_green[lnas_pkg::PROD_W-1:lnas_pkg::GAIN_SHIFT];
    assign w_sh_blue  = r2_blue[lnas_pkg::PROD_W-1:lnas_pkg::GAIN_SHIFT];

    always_comb begin
        n_rgb.red   = (w_sh_red > lnas_pkg::SAT_LIMIT)
                    ? lnas_pkg::CH_W'(lnas_pkg::SAT_LIMIT) : lnas_pkg::CH_W'(w_sh_red);
        n_rgb.green = (w_sh_green > lnas_pkg::SAT_LIMIT)
                    ? lnas_pkg::CH_W'(lnas_pkg::SAT_LIMIT) : lnas_pkg::CH_W'(w_sh_green);
        n_rgb.blue  = (w_sh_blue > lnas_pkg::SAT_LIMIT)
                    ? lnas_pkg::CH_W'(lnas_pkg::SAT_LIMIT) : lnas_pkg::CH_W'(w_sh_blue);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (w_rdy3) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy3) begin
            r3_rgb  <= n_rgb;
            r3_last <= r2_last;
        end
    end

    assign o_valid = r3_valid;
    assign o_rgb   = r3_rgb;
    assign o_last  = r3_last;

endmodule

`default_nettype wire

// ----- rtl/core/light_neighbor_average_stencil_unit.sv -----
// ----------------------------------------------------------------------------
// light_neighbor_average_stencil_unit
// Four-neighbor light averaging stencil over a raster RGB stream, one row lag.
// A result leaves on m_axis after the word that causes it has passed the read
// stage, four accumulate cells and three scale stages.
// Throughput: one word per cycle while m_axis accepts results; each row bank
// writes one entry and reads two per cycle.
// Reset: counters cleared, registers to defaults, pipeline emptied; the row
// store is not cleared and holds garbage until written.
// ----------------------------------------------------------------------------
`default_nettype none

module light_neighbor_average_stencil_unit (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // APB configuration port
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire [lnas_pkg::PADDR_W-1:0]      paddr,
    input  wire [lnas_pkg::PDATA_W-1:0]      pwdata,
    output logic [lnas_pkg::PDATA_W-1:0]     prdata,
    output logic                             pready,
    // Pixel input stream
    input  wire                              s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire [47:0]                       s_axis_tdata,  // in_red, in_green, in_blue
    input  wire                              s_axis_tuser,  // mode (1 = drain word)
    // Result stream
    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    output logic [47:0]                      m_axis_tdata,  // out_red, out_green, out_blue
    output logic                             m_axis_tlast   // frame_last
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [lnas_pkg::FW_W-1:0]   r_frame_width;
    logic [lnas_pkg::FH_W-1:0]   r_frame_height;
    logic [lnas_pkg::GAIN_W-1:0] r_falloff_gain;
    logic [1:0]                  w_reg_idx;
    logic                        w_cfg_wr;

    assign pready    = 1'b1;
    assign w_reg_idx = paddr[lnas_pkg::PADDR_W-1:2];
    assign w_cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= lnas_pkg::RST_FRAME_WIDTH;
            r_frame_height <= lnas_pkg::RST_FRAME_HEIGHT;
            r_falloff_gain <= lnas_pkg::RST_FALLOFF_GAIN;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                lnas_pkg::REG_FRAME_WIDTH:  r_frame_width  <= pwdata[lnas_pkg::FW_W-1:0];
                lnas_pkg::REG_FRAME_HEIGHT: r_frame_height <= pwdata[lnas_pkg::FH_W-1:0];
                lnas_pkg::REG_FALLOFF_GAIN: r_falloff_gain <= pwdata[lnas_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        case (w_reg_idx)
            lnas_pkg::REG_FRAME_WIDTH:  prdata = lnas_pkg::PDATA_W'(r_frame_width);
            lnas_pkg::REG_FRAME_HEIGHT: prdata = lnas_pkg::PDATA_W'(r_frame_height);
            lnas_pkg::REG_FALLOFF_GAIN: prdata = lnas_pkg::PDATA_W'(r_falloff_gain);
            default:                    prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Effective frame size
    // ------------------------------------------------------------------
    logic [lnas_pkg::WCNT_W-1:0] w_eff_w;
    logic [lnas_pkg::WCNT_W-1:0] w_eff_w_m1;
    logic [lnas_pkg::FH_W-1:0]   w_eff_h;

    always_comb begin
        if (r_frame_width == '0) begin
            w_eff_w = lnas_pkg::WCNT_W'(1);
        end else if (32'(r_frame_width) > lnas_pkg::MAX_WIDTH) begin
            w_eff_w = lnas_pkg::WCNT_W'(lnas_pkg::MAX_WIDTH);
        end else begin
            w_eff_w = lnas_pkg::WCNT_W'(r_frame_width);
        end
        w_eff_w_m1 = w_eff_w - lnas_pkg::WCNT_W'(1);
        w_eff_h    = (r_frame_height == '0) ? lnas_pkg::FH_W'(1) : r_frame_height;
    end

    // ------------------------------------------------------------------
    // Position counters and word decode
    // ------------------------------------------------------------------
    logic [lnas_pkg::ADDR_W-1:0] r_col, r_drain;
    logic [lnas_pkg::FH_W-1:0]   r_row;

    logic                        w_accept, w_mode, w_pending;
    logic                        w_pix_ok, w_drain_ok, w_emit;
    logic [lnas_pkg::ADDR_W-1:0] w_pos, w_x, w_x_p1, w_x_m1;
    logic                        w_last_col;
    logic                        w_near;
    lnas_pkg::t_rgb              w_px;
    logic                        w_s0_en;

    assign w_mode      = s_axis_tuser;
    assign w_px.red    = s_axis_tdata[15:0];
    assign w_px.green  = s_axis_tdata[31:16];
    assign w_px.blue   = s_axis_tdata[47:32];
    assign w_accept    = s_axis_tvalid && s_axis_tready;
    assign w_pending   = (r_row >= w_eff_h);
    assign w_pix_ok    = w_accept && !w_mode && !w_pending;
    assign w_drain_ok  = w_accept && w_mode && w_pending;
    assign w_emit      = (w_pix_ok && (r_row != '0)) || w_drain_ok;

    // Column of this word, a counter past the width acts as the last column
    assign w_pos      = w_mode ? r_drain : r_col;
    assign w_x        = (lnas_pkg::WCNT_W'(w_pos) >= w_eff_w)
                      ? w_eff_w_m1[lnas_pkg::ADDR_W-1:0] : w_pos;
    assign w_last_col = (lnas_pkg::WCNT_W'(w_x) == w_eff_w_m1);
    assign w_x_p1     = w_x + lnas_pkg::ADDR_W'(1);
    assign w_x_m1     = w_x - lnas_pkg::ADDR_W'(1);

    // Bank of the row being emitted; the other bank holds the row above it
    assign w_near = ~r_row[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_drain <= '0;
        end else if (w_pix_ok) begin
            if (w_last_col) begin
                r_col <= '0;
                r_row <= r_row + lnas_pkg::FH_W'(1);
            end else begin
                r_col <= w_x_p1;
            end
        end else if (w_drain_ok) begin
            if (w_last_col) begin
                r_col   <= '0;
                r_row   <= '0;
                r_drain <= '0;
            end else begin
                r_drain <= w_x_p1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Row store: two banks by row parity, one write and two reads each
    // ------------------------------------------------------------------
    lnas_pkg::t_rgb              r_mem0 [lnas_pkg::MAX_WIDTH];
    lnas_pkg::t_rgb              r_mem1 [lnas_pkg::MAX_WIDTH];
    lnas_pkg::t_rgb              r_rd1_b0, r_rd2_b0, r_rd1_b1, r_rd2_b1;
    logic [lnas_pkg::ADDR_W-1:0] w_a1_b0, w_a1_b1;
    logic                        w_wr_b0, w_wr_b1;

    // Near bank reads right and left, far bank reads the entry above
    assign w_a1_b0 = (w_near == 1'b0) ? w_x_p1 : w_x;
    assign w_a1_b1 = (w_near == 1'b1) ? w_x_p1 : w_x;
    assign w_wr_b0 = w_pix_ok && (r_row[0] == 1'b0);
    assign w_wr_b1 = w_pix_ok && (r_row[0] == 1'b1);

    always_ff @(posedge i_clk) begin
        if (w_wr_b0) begin
            r_mem0[w_x] <= w_px;
        end
        if (w_s0_en) begin
            r_rd1_b0 <= r_mem0[w_a1_b0];
            r_rd2_b0 <= r_mem0[w_x_m1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_b1) begin
            r_mem1[w_x] <= w_px;
        end
        if (w_s0_en) begin
            r_rd1_b1 <= r_mem1[w_a1_b1];
            r_rd2_b1 <= r_mem1[w_x_m1];
        end
    end

    // ------------------------------------------------------------------
    // Read stage: side information aligned with the store read data
    // ------------------------------------------------------------------
    logic                          r_s0_valid;
    logic                          r_s0_last;
    logic                          r_s0_near;
    logic [lnas_pkg::NUM_OPS-1:0]  r_s0_pres;
    lnas_pkg::t_rgb                r_s0_down;
    logic [lnas_pkg::NUM_OPS-1:0]  n_s0_pres;

    lnas_pkg::t_cell_bus chain_bus [lnas_pkg::NUM_OPS+1];
    logic                chain_rdy [lnas_pkg::NUM_OPS+1];

    assign w_s0_en       = !r_s0_valid || chain_rdy[0];
    assign s_axis_tready = w_s0_en;

    always_comb begin
        n_s0_pres                    = '0;
        n_s0_pres[lnas_pkg::OP_RIGHT] = !w_last_col;
        n_s0_pres[lnas_pkg::OP_LEFT]  = (w_x != '0);
        n_s0_pres[lnas_pkg::OP_DOWN]  = !w_mode;
        n_s0_pres[lnas_pkg::OP_UP]    = (r_row > lnas_pkg::FH_W'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (w_s0_en) begin
            r_s0_valid <= w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s0_en) begin
            r_s0_last <= w_drain_ok && w_last_col;
            r_s0_near <= w_near;
            r_s0_pres <= n_s0_pres;
            r_s0_down <= w_px;
        end
    end

    // Word entering the cell chain
    always_comb begin
        chain_bus[0]       = '0;
        chain_bus[0].valid = r_s0_valid;
        chain_bus[0].last  = r_s0_last;
        chain_bus[0].ops[lnas_pkg::OP_RIGHT].present = r_s0_pres[lnas_pkg::OP_RIGHT];
        chain_bus[0].ops[lnas_pkg::OP_RIGHT].rgb     = r_s0_near ? r_rd1_b1 : r_rd1_b0;
        chain_bus[0].ops[lnas_pkg::OP_LEFT].present  = r_s0_pres[lnas_pkg::OP_LEFT];
        chain_bus[0].ops[lnas_pkg::OP_LEFT].rgb      = r_s0_near ? r_rd2_b1 : r_rd2_b0;
        chain_bus[0].ops[lnas_pkg::OP_DOWN].present  = r_s0_pres[lnas_pkg::OP_DOWN];
        chain_bus[0].ops[lnas_pkg::OP_DOWN].rgb      = r_s0_down;
        chain_bus[0].ops[lnas_pkg::OP_UP].present    = r_s0_pres[lnas_pkg::OP_UP];
        chain_bus[0].ops[lnas_pkg::OP_UP].rgb        = r_s0_near ? r_rd1_b0 : r_rd1_b1;
    end

    // ------------------------------------------------------------------
    // Accumulate cell chain, one neighbor per cell
    // ------------------------------------------------------------------
    for (genvar gc = 0; gc < lnas_pkg::NUM_OPS; gc++) begin : gen_cell
        lnas_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_bus   (chain_bus[gc]),
            .o_ready (chain_rdy[gc]),
            .i_ready (chain_rdy[gc+1]),
            .o_bus   (chain_bus[gc+1])
        );
    end

    // ------------------------------------------------------------------
    // Scale and saturate, ends in the output register
    // ------------------------------------------------------------------
    lnas_pkg::t_rgb w_out_rgb;

    lnas_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_gain  (r_falloff_gain),
        .i_bus   (chain_bus[lnas_pkg::NUM_OPS]),
        .o_ready (chain_rdy[lnas_pkg::NUM_OPS]),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_rgb   (w_out_rgb),
        .o_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {w_out_rgb.blue, w_out_rgb.green, w_out_rgb.red};

endmodule

`default_nettype wire
